// File: hdl/duplicate_packet_cache_defines.svh
// Assertion macros shared by the duplicate packet cache RTL.
`ifndef DUPLICATE_PACKET_CACHE_DEFINES_SVH
`define DUPLICATE_PACKET_CACHE_DEFINES_SVH

`ifndef ASSERT_OFF
// Checks that a condition holds at every clock edge outside reset.
`define DPC_ASSERT_ALWAYS(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("assertion failed: condition does not hold");
// Checks that a trigger is followed by a consequence in the next cycle.
`define DPC_ASSERT_NEXT(label, clk, rst_n, trig, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
        else $error("assertion failed: consequence missing after trigger");
`else
`define DPC_ASSERT_ALWAYS(label, clk, rst_n, cond)
`define DPC_ASSERT_NEXT(label, clk, rst_n, trig, cons)
`endif

`endif

// File: hdl/dpc_pkg.sv
// Package with the types and fixed constants of the duplicate packet cache.
package dpc_pkg;

    // Field widths of one input item.
    localparam int SENDER_W = 16;
    localparam int SERIAL_W = 32;
    localparam int ENTRY_W  = SENDER_W + SERIAL_W;

    // Capacity register width and reset value.
    localparam int             CAP_W     = 6;
    localparam logic [CAP_W-1:0] CAP_RESET = 6'd32;

    // Sequencer states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_WRITE,
        S_FINISH
    } t_state;

endpackage

// File: hdl/duplicate_packet_cache.sv
// Top level of the duplicate packet cache: sequencer, entry memory and output register.
// Each item (sender_id, serial_number) is compared against the valid cache entries,
// which are read one per cycle from a single synchronous memory (registered read port).
// An item passes through acceptance, one read per valid entry with the compare of the last
// read following it, a write on a miss and the load of the output register, which waits
// while the output is stalled; a hit ends the scan early and skips the write. One item is
// in work at a time; the output register lets the next item be accepted while a result
// still waits. A miss stores the pair in the next free slot, or, once capacity entries are
// held, over the oldest entry. Writing the capacity register (0 acts as 1, values above
// DEPTH act as DEPTH) empties the cache at once; no clearing pass is needed after reset.
`include "duplicate_packet_cache_defines.svh"

module duplicate_packet_cache #(
    parameter int DEPTH = 32
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // Configuration write port
    input  logic                           i_cfg_we,
    input  logic [dpc_pkg::CAP_W-1:0]      i_cfg_wdata,
    // Input channel
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic [dpc_pkg::SENDER_W-1:0]   i_sender_id,
    input  logic [dpc_pkg::SERIAL_W-1:0]   i_serial_number,
    // Output channel
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic                           o_duplicate
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    dpc_pkg::t_state r_state, n_state;

    logic [dpc_pkg::CAP_W-1:0]    r_cap;
    logic [CW-1:0]                r_count;
    logic [AW-1:0]                r_oldest;
    logic [CW-1:0]                r_idx;
    logic                         r_cmp_valid;
    logic                         r_dup;
    logic                         r_out_valid;
    logic                         r_out_dup;
    logic [dpc_pkg::SENDER_W-1:0] r_sid;
    logic [dpc_pkg::SERIAL_W-1:0] r_sn;

    logic [dpc_pkg::ENTRY_W-1:0]  r_mem [DEPTH];
    logic [dpc_pkg::ENTRY_W-1:0]  r_rd_data;

    logic [31:0]   w_cap32;
    logic [31:0]   w_eff32;
    logic [CW-1:0] w_eff;
    logic          w_accept;
    logic          w_more;
    logic          w_match;
    logic          w_has_room;
    logic [AW-1:0] w_slot;
    logic [AW-1:0] w_oldest_next;
    logic          w_rd_en;
    logic          w_mem_we;
    logic          w_out_free;

    // Effective capacity: the register value clamped to 1 .. DEPTH.
    always_comb begin
        w_cap32 = 32'(r_cap);
        if (w_cap32 == 32'd0) begin
            w_eff32 = 32'd1;
        end else if (w_cap32 > 32'(DEPTH)) begin
            w_eff32 = 32'(DEPTH);
        end else begin
            w_eff32 = w_cap32;
        end
        w_eff = CW'(w_eff32);
    end

    // Scan status and replacement slot selection.
    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_more     = (r_idx < r_count);
    assign w_match    = r_cmp_valid && (r_rd_data == {r_sid, r_sn});
    assign w_has_room = (r_count < w_eff);
    assign w_slot     = w_has_room ? r_count[AW-1:0] : r_oldest;
    assign w_out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        if ((32'(r_oldest) + 32'd1) >= w_eff32) begin
            w_oldest_next = '0;
        end else begin
            w_oldest_next = r_oldest + AW'(1);
        end
    end

    // Next-state logic.
    always_comb begin
        n_state = r_state;
        case (r_state)
            dpc_pkg::S_IDLE: begin
                if (w_accept) begin
                    n_state = dpc_pkg::S_SCAN;
                end
            end
            dpc_pkg::S_SCAN: begin
                if (w_match) begin
                    n_state = dpc_pkg::S_FINISH;
                end else if (!w_more) begin
                    n_state = dpc_pkg::S_WRITE;
                end
            end
            dpc_pkg::S_WRITE: begin
                n_state = dpc_pkg::S_FINISH;
            end
            dpc_pkg::S_FINISH: begin
                if (w_out_free) begin
                    n_state = dpc_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = dpc_pkg::S_IDLE;
            end
        endcase
    end

    // State-decoded outputs and memory controls.
    always_comb begin
        o_in_stall = 1'b1;
        w_rd_en    = 1'b0;
        w_mem_we   = 1'b0;
        case (r_state)
            dpc_pkg::S_IDLE: begin
                o_in_stall = 1'b0;
            end
            dpc_pkg::S_SCAN: begin
                w_rd_en = w_more;
            end
            dpc_pkg::S_WRITE: begin
                w_mem_we = 1'b1;
            end
            default: begin
                o_in_stall = 1'b1;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= dpc_pkg::S_IDLE;
            r_cap       <= dpc_pkg::CAP_RESET;
            r_count     <= '0;
            r_oldest    <= '0;
            r_idx       <= '0;
            r_cmp_valid <= 1'b0;
            r_dup       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;

            // Scan pointer: one read issued per cycle, compare follows in the next cycle.
            if (w_accept) begin
                r_idx       <= '0;
                r_cmp_valid <= 1'b0;
            end else if (r_state == dpc_pkg::S_SCAN) begin
                r_cmp_valid <= w_more;
                if (w_more) begin
                    r_idx <= r_idx + CW'(1);
                end
            end

            // Verdict for the item in work.
            if (r_state == dpc_pkg::S_SCAN && w_match) begin
                r_dup <= 1'b1;
            end else if (r_state == dpc_pkg::S_WRITE) begin
                r_dup <= 1'b0;
            end

            // Fill count and FIFO replacement pointer.
            if (i_cfg_we) begin
                r_cap    <= i_cfg_wdata;
                r_count  <= '0;
                r_oldest <= '0;
            end else if (w_mem_we) begin
                if (w_has_room) begin
                    r_count <= r_count + CW'(1);
                end else begin
                    r_oldest <= w_oldest_next;
                end
            end

            // Output register handshake.
            if (r_state == dpc_pkg::S_FINISH && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers: the item in work and the result on the output.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_sid <= i_sender_id;
            r_sn  <= i_serial_number;
        end
        if (r_state == dpc_pkg::S_FINISH && w_out_free) begin
            r_out_dup <= r_dup;
        end
    end

    // Entry memory: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_mem[w_slot] <= {r_sid, r_sn};
        end
        if (w_rd_en) begin
            r_rd_data <= r_mem[r_idx[AW-1:0]];
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_duplicate = r_out_dup;

    // The fill count never exceeds the effective capacity.
    `DPC_ASSERT_ALWAYS(a_count_in_range, i_clk, i_rst_n, r_count <= w_eff)
    // The replacement pointer always lies below the effective capacity.
    `DPC_ASSERT_ALWAYS(a_oldest_in_range, i_clk, i_rst_n, 32'(r_oldest) < w_eff32)
    // An accepted item always starts a scan.
    `DPC_ASSERT_NEXT(a_accept_scan, i_clk, i_rst_n, w_accept, r_state == dpc_pkg::S_SCAN)
    // After a store the cache holds at least one entry.
    `DPC_ASSERT_NEXT(a_write_fills, i_clk, i_rst_n, w_mem_we && !i_cfg_we, r_count != '0)

endmodule
